[hdl/ccc_pkg.sv]
// Shared types, codes and constants for the calendar clock counter.
// No dependencies; imported by every module under hdl/.
package ccc_pkg;

    // tenths counter wraps at this count (range 2..16)
    localparam logic [4:0] TICKS_PER_SECOND = 5'd10;

    localparam logic [5:0]  MAX_SECOND = 6'd59;
    localparam logic [5:0]  MAX_MINUTE = 6'd59;
    localparam logic [4:0]  MAX_HOUR   = 5'd23;
    localparam logic [4:0]  MAX_DAY    = 5'd31;
    localparam logic [3:0]  MAX_MONTH  = 4'd12;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [4:0]  NOON_HOUR  = 5'd12;

    // request codes carried on tuser
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_SET_TIME = 2'd1;
    localparam logic [1:0] REQ_SET_DATE = 2'd2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [3:0]  tenths;
    } t_time;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [5:0]  minute;
        logic [4:0]  hour;
    } t_set;

    typedef struct packed {
        logic [4:0] hour;
        logic       pm;
    } t_disp;

    localparam t_time TIME_RESET = '{
        year: 14'd2019, month: 4'd2, day: 5'd11, hour: 5'd19,
        minute: 6'd12, second: 6'd5, tenths: 4'd0
    };

    // days in a month; leap year when year mod 4 is 0
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] len;
        len = 5'd31;
        if (m == 4'd2) begin
            len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

[hdl/ccc_next.sv]
// Next time/date value for one word: tick carry chain, set-time and set-date loads.
// Depends on ccc_pkg.
module ccc_next
    import ccc_pkg::*;
(
    input  t_time      i_cur,
    input  logic [1:0] i_req,
    input  t_set       i_set,
    output t_time      o_nxt
);

    logic [4:0]  w_tenths_p;
    logic [6:0]  w_second_p;
    logic [6:0]  w_minute_p;
    logic [5:0]  w_hour_p;
    logic [5:0]  w_day_p;
    logic [4:0]  w_month_p;
    logic [14:0] w_year_p;
    logic [4:0]  w_mlen;

    assign w_tenths_p = {1'b0, i_cur.tenths} + 5'd1;
    assign w_second_p = {1'b0, i_cur.second} + 7'd1;
    assign w_minute_p = {1'b0, i_cur.minute} + 7'd1;
    assign w_hour_p   = {1'b0, i_cur.hour} + 6'd1;
    assign w_day_p    = {1'b0, i_cur.day} + 6'd1;
    assign w_month_p  = {1'b0, i_cur.month} + 5'd1;
    assign w_year_p   = {1'b0, i_cur.year} + 15'd1;
    assign w_mlen     = month_len(i_cur.month, i_cur.year);

    always_comb begin
        o_nxt = i_cur;
        unique case (i_req)
            REQ_TICK: begin
                if (w_tenths_p < TICKS_PER_SECOND) begin
                    o_nxt.tenths = w_tenths_p[3:0];
                end else begin
                    o_nxt.tenths = '0;
                    if (w_second_p <= {1'b0, MAX_SECOND}) begin
                        o_nxt.second = w_second_p[5:0];
                    end else begin
                        o_nxt.second = '0;
                        if (w_minute_p <= {1'b0, MAX_MINUTE}) begin
                            o_nxt.minute = w_minute_p[5:0];
                        end else begin
                            o_nxt.minute = '0;
                            if (w_hour_p <= {1'b0, MAX_HOUR}) begin
                                o_nxt.hour = w_hour_p[4:0];
                            end else begin
                                o_nxt.hour = '0;
                                // day rollover; a loaded day past month end also lands here
                                if (w_day_p <= {1'b0, w_mlen}) begin
                                    o_nxt.day = w_day_p[4:0];
                                end else begin
                                    o_nxt.day = 5'd1;
                                    if (w_month_p <= {1'b0, MAX_MONTH}) begin
                                        o_nxt.month = w_month_p[3:0];
                                    end else begin
                                        o_nxt.month = 4'd1;
                                        o_nxt.year  = (w_year_p > {1'b0, MAX_YEAR}) ?
                                                      14'd0 : w_year_p[13:0];
                                    end
                                end
                            end
                        end
                    end
                end
            end
            REQ_SET_TIME: begin
                o_nxt.hour   = (i_set.hour > MAX_HOUR) ? MAX_HOUR : i_set.hour;
                o_nxt.minute = (i_set.minute > MAX_MINUTE) ? MAX_MINUTE : i_set.minute;
                o_nxt.second = '0;
                o_nxt.tenths = '0;
            end
            REQ_SET_DATE: begin
                // day field is 5 bits, so only the zero case needs raising
                o_nxt.day   = (i_set.day == 5'd0) ? 5'd1 : i_set.day;
                o_nxt.month = (i_set.month == 4'd0) ? 4'd1 :
                              (i_set.month > MAX_MONTH) ? MAX_MONTH : i_set.month;
                o_nxt.year  = (i_set.year > MAX_YEAR) ? MAX_YEAR : i_set.year;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

[hdl/ccc_display.sv]
// 12/24-hour display hour and PM flag from the 24-hour count.
// Depends on ccc_pkg.
module ccc_display
    import ccc_pkg::*;
(
    input  logic [4:0] i_hour,
    input  logic       i_mode_24,
    output t_disp      o_disp
);

    always_comb begin
        priority if (i_mode_24) begin
            o_disp = '{hour: i_hour, pm: 1'b0};
        end else if (i_hour == 5'd0) begin
            o_disp = '{hour: NOON_HOUR, pm: 1'b0};   // midnight
        end else if (i_hour < NOON_HOUR) begin
            o_disp = '{hour: i_hour, pm: 1'b0};
        end else if (i_hour == NOON_HOUR) begin
            o_disp = '{hour: NOON_HOUR, pm: 1'b1};   // noon
        end else begin
            o_disp = '{hour: i_hour - NOON_HOUR, pm: 1'b1};
        end
    end

endmodule

[hdl/calendar_clock_counter.sv]
// Top level of the calendar clock counter: input register, time/date state,
// result register. Depends on ccc_pkg, ccc_next and ccc_display.
//
// Real-time clock and calendar. Each word on the slave stream is a tick of one
// tenth second (tuser 0), a set-time (tuser 1: hour and minute, seconds and
// tenths cleared) or a set-date (tuser 2: day, month, year); tuser 3 changes
// nothing. Out-of-range set values clamp to the field maximum, a day or month
// of 0 reads as 1. Every word yields exactly one result word with the updated
// date and time, plus a display hour: the 24-hour value when hour_mode_24 is
// set, else 1..12 with a PM flag (noon is 12 PM, midnight 12 AM). Months have
// 30 or 31 days, February 29 when year mod 4 is 0; year 9999 wraps to 0.
// Rate: one word per cycle sustained while the master side is ready. A word
// taken is held in the input register while the combinational carry chain
// settles, and its result is loaded into the result register once that slot
// is free or draining; it shows on the master side from there. Up to two words
// are held (input and result register) while the master side stalls.
// Reset state is 2019-02-11 19:12:05.0, 12-hour mode.
// Write i_cfg_wdata with i_cfg_we only while the stream is idle.
module calendar_clock_counter
    import ccc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,      // hour_mode_24

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] set_hour, [10:5] set_minute, [15:11] set_day, [19:16] set_month,
    // [33:20] set_year, [39:34] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,     // [1:0] req_type

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_out, [27:23] hour_out,
    // [33:28] minute_out, [39:34] second_out, [43:40] tenths_out,
    // [48:44] display_hour, [49] pm_flag, [55:50] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_req;
    t_set       r_in_set;

    // state and result register
    t_time      r_time;
    logic       r_mode_24;
    logic       r_out_valid;
    t_time      r_out_time;
    t_disp      r_out_disp;

    t_time      n_time;
    t_disp      n_disp;
    logic       w_adv;

    // the input register moves on whenever the result slot is free or draining
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    ccc_next u_next (
        .i_cur (r_time),
        .i_req (r_in_req),
        .i_set (r_in_set),
        .o_nxt (n_time)
    );

    ccc_display u_display (
        .i_hour    (n_time.hour),
        .i_mode_24 (r_mode_24),
        .o_disp    (n_disp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_time      <= TIME_RESET;
            r_mode_24   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode_24 <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_time      <= n_time;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req <= s_axis_tuser;
            r_in_set <= '{
                hour:   s_axis_tdata[4:0],
                minute: s_axis_tdata[10:5],
                day:    s_axis_tdata[15:11],
                month:  s_axis_tdata[19:16],
                year:   s_axis_tdata[33:20]
            };
        end
        if (w_adv) begin
            r_out_time <= n_time;
            r_out_disp <= n_disp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_disp.pm, r_out_disp.hour,
                            r_out_time.tenths, r_out_time.second, r_out_time.minute,
                            r_out_time.hour, r_out_time.day, r_out_time.month,
                            r_out_time.year};

    // no result survives reset
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an advancing word always lands in the result register
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> m_axis_tvalid)
        else $error("advanced word lost");

    // a word taken on the slave side is held in the input register
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_valid)
        else $error("accepted word dropped");

    // set-time clears seconds and tenths in state, and tenths in the result
    a_set_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_req == REQ_SET_TIME |=>
        r_time.second == 6'd0 && r_time.tenths == 4'd0 && r_out_time.tenths == 4'd0)
        else $error("set time did not clear seconds");

    // hour, month, tenths and the lower bound of day stay within their ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time.hour <= MAX_HOUR && r_time.month >= 4'd1 && r_time.month <= MAX_MONTH &&
        r_time.day >= 5'd1 && {1'b0, r_time.tenths} < TICKS_PER_SECOND)
        else $error("time counter out of range");

endmodule
